/* rtl/core/rds_group_dispatcher_macros.svh */
// Assertion macros for the RDS group dispatcher.
`ifndef RDS_GROUP_DISPATCHER_MACROS_SVH
`define RDS_GROUP_DISPATCHER_MACROS_SVH

`ifndef SYNTHESIS

`define RGD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgd assertion failed");

`define RGD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgd assertion failed");

`else

`define RGD_ASSERT_IMP(label, clk, rst, ante, cons)

`define RGD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/rgd_pkg.sv */
// Shared types and constants of the RDS group dispatcher.
package rgd_pkg;

   localparam int unsigned SlotCount  = 9;
   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QPtrWidth  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

   localparam logic [1:0] BlockBMaxReset = 2'd1;
   localparam logic [1:0] OtherMaxReset  = 2'd2;

   localparam logic CSR_BLOCK_B_MAX = 1'b0;
   localparam logic CSR_OTHER_MAX   = 1'b1;

   localparam logic [4:0] GTYPE_0A = 5'd0;
   localparam logic [4:0] GTYPE_0B = 5'd1;
   localparam logic [4:0] GTYPE_2A = 5'd4;
   localparam logic [4:0] GTYPE_2B = 5'd5;

   typedef enum logic [2:0] {
      EV_PI  = 3'd0,
      EV_PTY = 3'd1,
      EV_TP  = 3'd2,
      EV_AF  = 3'd3,
      EV_TA  = 3'd4,
      EV_PS  = 3'd5,
      EV_RT  = 3'd6
   } rgd_kind_type;

   // Candidate events of one group, in the order they are sent.
   typedef enum logic [3:0] {
      SLOT_PI_A  = 4'd0,
      SLOT_PI_C  = 4'd1,
      SLOT_PTY   = 4'd2,
      SLOT_TP    = 4'd3,
      SLOT_AF    = 4'd4,
      SLOT_TA    = 4'd5,
      SLOT_PS_HI = 4'd6,
      SLOT_PS_LO = 4'd7,
      SLOT_RT    = 4'd8
   } rgd_slot_type;

   typedef struct packed {
      logic [SlotCount-1:0] mask;
      logic [15:0]          word_a;
      logic [15:0]          word_b;
      logic [15:0]          word_c;
      logic [15:0]          word_d;
   } rgd_entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } rgd_q_status_type;

endpackage

/* rtl/core/rgd_front.sv */
// Front end: configuration registers and classification of incoming groups.
module rgd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic                  req_group_valid,
   input  logic [1:0]            req_err_a,
   input  logic [1:0]            req_err_b,
   input  logic [1:0]            req_err_c,
   input  logic [1:0]            req_err_d,
   input  logic [15:0]           req_word_a,
   input  logic [15:0]           req_word_b,
   input  logic [15:0]           req_word_c,
   input  logic [15:0]           req_word_d,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [1:0]            csr_wdata,
   output logic                  push,
   output rgd_pkg::rgd_entry_type push_entry
);
   import rgd_pkg::*;

   logic [1:0] b_max_ff, b_max_in;
   logic [1:0] o_max_ff, o_max_in;
   logic       keep, a_ok, c_ok, d_ok, ps_group;
   logic [4:0] gtype;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_max_ff <= BlockBMaxReset;
         o_max_ff <= OtherMaxReset;
      end else begin
         b_max_ff <= b_max_in;
         o_max_ff <= o_max_in;
      end
   end

   always_comb begin
      b_max_in = b_max_ff;
      o_max_in = o_max_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLOCK_B_MAX: b_max_in = csr_wdata;
            CSR_OTHER_MAX:   o_max_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      keep     = req_group_valid && (req_err_b <= b_max_ff);
      a_ok     = req_err_a <= o_max_ff;
      c_ok     = req_err_c <= o_max_ff;
      d_ok     = req_err_d <= o_max_ff;
      gtype    = req_word_b[15:11];
      ps_group = (gtype == GTYPE_0A) || (gtype == GTYPE_0B);

      push_entry.word_a = req_word_a;
      push_entry.word_b = req_word_b;
      push_entry.word_c = req_word_c;
      push_entry.word_d = req_word_d;
      push_entry.mask   = '0;
      push_entry.mask[SLOT_PI_A]  = a_ok;
      push_entry.mask[SLOT_PI_C]  = gtype[0] && c_ok;
      push_entry.mask[SLOT_PTY]   = 1'b1;
      push_entry.mask[SLOT_TP]    = 1'b1;
      push_entry.mask[SLOT_AF]    = (gtype == GTYPE_0A) && c_ok;
      push_entry.mask[SLOT_TA]    = ps_group;
      push_entry.mask[SLOT_PS_HI] = ps_group && d_ok;
      push_entry.mask[SLOT_PS_LO] = ps_group && d_ok;
      push_entry.mask[SLOT_RT]    = ((gtype == GTYPE_2A) && c_ok && d_ok)
                                 || ((gtype == GTYPE_2B) && d_ok);

      push = start && !busy && keep;
   end

endmodule

/* rtl/core/rgd_queue.sv */
// Short queue of classified groups between the front and back ends.
module rgd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rgd_pkg::rgd_entry_type   push_entry,
   input  logic                     pop,
   output rgd_pkg::rgd_entry_type   head_entry,
   output rgd_pkg::rgd_q_status_type status
);
   import rgd_pkg::*;

   rgd_entry_type        entries_ff [QueueDepth];
   logic [QPtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntWidth-1:0] count_ff, count_in;

   function automatic logic [QPtrWidth-1:0] ptr_next(input logic [QPtrWidth-1:0] ptr);
      logic [QPtrWidth-1:0] nxt;
      if (ptr == QPtrWidth'(QueueDepth - 1)) nxt = '0;
      else nxt = ptr + QPtrWidth'(1);
      return nxt;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + QCntWidth'(1);
      else if (pop && !push) count_in = count_ff - QCntWidth'(1);
      head_entry       = entries_ff[rd_ptr_ff];
      status.not_empty = count_ff != '0;
      status.full      = count_ff == QCntWidth'(QueueDepth);
   end

endmodule

/* rtl/core/rgd_back.sv */
// Back end: walks the event mask of one group and sends one event word per cycle.
module rgd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rgd_pkg::rgd_q_status_type q_status,
   input  rgd_pkg::rgd_entry_type    head_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_event_kind,
   output logic [15:0]               rsp_event_value,
   output logic [3:0]                rsp_char_address,
   output logic                      rsp_text_ab,
   output logic [2:0]                rsp_char_count,
   output logic [7:0]                rsp_char0,
   output logic [7:0]                rsp_char1,
   output logic [7:0]                rsp_char2,
   output logic [7:0]                rsp_char3,
   output logic                      rsp_last
);
   import rgd_pkg::*;

   rgd_entry_type        cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   rgd_slot_type         sel;
   logic                 found;
   logic [SlotCount-1:0] remaining;
   logic                 last_now;

   logic         rsp_valid_ff;
   rgd_kind_type kind_ff, kind_in;
   logic [15:0]  value_ff, value_in;
   logic [3:0]   addr_ff, addr_in;
   logic         ab_ff, ab_in;
   logic [2:0]   count_ff, count_in;
   logic [7:0]   c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in, c3_ff, c3_in;
   logic         last_ff;

   always_comb begin
      sel   = SLOT_PI_A;
      found = 1'b0;
      for (int i = 0; i < SlotCount; i++) begin
         if (!found && cur_ff.mask[i]) begin
            sel   = rgd_slot_type'(i[3:0]);
            found = 1'b1;
         end
      end
      remaining = cur_ff.mask & ~(SlotCount'(1) << sel);
      last_now  = remaining == '0;
      pop       = q_status.not_empty && (!cur_valid_ff || last_now);

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      if (pop) begin
         cur_in       = head_entry;
         cur_valid_in = 1'b1;
      end else if (cur_valid_ff) begin
         cur_in.mask  = remaining;
         cur_valid_in = !last_now;
      end
   end

   always_comb begin
      kind_in  = EV_PI;
      value_in = '0;
      addr_in  = '0;
      ab_in    = 1'b0;
      count_in = '0;
      c0_in    = '0;
      c1_in    = '0;
      c2_in    = '0;
      c3_in    = '0;
      unique case (sel)
         SLOT_PI_A: value_in = cur_ff.word_a;
         SLOT_PI_C: value_in = cur_ff.word_c;
         SLOT_PTY: begin
            kind_in  = EV_PTY;
            value_in = {11'd0, cur_ff.word_b[9:5]};
         end
         SLOT_TP: begin
            kind_in  = EV_TP;
            value_in = {15'd0, cur_ff.word_b[10]};
         end
         SLOT_AF: begin
            kind_in  = EV_AF;
            value_in = cur_ff.word_c;
         end
         SLOT_TA: begin
            kind_in  = EV_TA;
            value_in = {15'd0, cur_ff.word_b[4]};
         end
         SLOT_PS_HI: begin
            kind_in  = EV_PS;
            addr_in  = {1'b0, cur_ff.word_b[1:0], 1'b0};
            count_in = 3'd1;
            c0_in    = cur_ff.word_d[15:8];
         end
         SLOT_PS_LO: begin
            kind_in  = EV_PS;
            addr_in  = {1'b0, cur_ff.word_b[1:0], 1'b1};
            count_in = 3'd1;
            c0_in    = cur_ff.word_d[7:0];
         end
         SLOT_RT: begin
            kind_in = EV_RT;
            addr_in = cur_ff.word_b[3:0];
            ab_in   = cur_ff.word_b[4];
            // Version B of group 2 carries two characters in block D only.
            if (cur_ff.word_b[11]) begin
               count_in = 3'd2;
               c0_in    = cur_ff.word_d[15:8];
               c1_in    = cur_ff.word_d[7:0];
            end else begin
               count_in = 3'd4;
               c0_in    = cur_ff.word_c[15:8];
               c1_in    = cur_ff.word_c[7:0];
               c2_in    = cur_ff.word_d[15:8];
               c3_in    = cur_ff.word_d[7:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= cur_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cur_valid_ff) begin
         kind_ff  <= kind_in;
         value_ff <= value_in;
         addr_ff  <= addr_in;
         ab_ff    <= ab_in;
         count_ff <= count_in;
         c0_ff    <= c0_in;
         c1_ff    <= c1_in;
         c2_ff    <= c2_in;
         c3_ff    <= c3_in;
         last_ff  <= last_now;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_event_value  = value_ff;
   assign rsp_char_address = addr_ff;
   assign rsp_text_ab      = ab_ff;
   assign rsp_char_count   = count_ff;
   assign rsp_char0        = c0_ff;
   assign rsp_char1        = c1_ff;
   assign rsp_char2        = c2_ff;
   assign rsp_char3        = c3_ff;
   assign rsp_last         = last_ff;

endmodule

/* rtl/core/rds_group_dispatcher.sv */
// Top level of the RDS group dispatcher: front end, group queue and event sequencer.
//
//   port group   direction   handshake           moves
//   req_*        in          start / busy        one received group
//   rsp_*        out         rsp_valid strobe    one event word, rsp_last on the final one
//   csr_*        in          csr_we              one configuration register write
//
// A group is accepted in any cycle in which the two-entry queue has room.
// Each kept group yields two to seven event words, one per cycle, from the
// back-end sequencer; a group passes through the queue and the current-group
// register, and each word is registered at the output.
// Reset is synchronous and empties the queue and the sequencer; the error
// limits return to 1 for block B and 2 for the other blocks.
// The receiver cannot stall; busy rises only while the queue is full.
`include "rds_group_dispatcher_macros.svh"

module rds_group_dispatcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_group_valid,
   input  logic [1:0]  req_err_a,
   input  logic [1:0]  req_err_b,
   input  logic [1:0]  req_err_c,
   input  logic [1:0]  req_err_d,
   input  logic [15:0] req_word_a,
   input  logic [15:0] req_word_b,
   input  logic [15:0] req_word_c,
   input  logic [15:0] req_word_d,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [1:0]  csr_wdata,
   output logic        rsp_valid,
   output logic [2:0]  rsp_event_kind,
   output logic [15:0] rsp_event_value,
   output logic [3:0]  rsp_char_address,
   output logic        rsp_text_ab,
   output logic [2:0]  rsp_char_count,
   output logic [7:0]  rsp_char0,
   output logic [7:0]  rsp_char1,
   output logic [7:0]  rsp_char2,
   output logic [7:0]  rsp_char3,
   output logic        rsp_last
);
   import rgd_pkg::*;

   logic             push, pop;
   rgd_entry_type    push_entry, head_entry;
   rgd_q_status_type q_status;

   assign busy = q_status.full;

   rgd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_group_valid (req_group_valid),
      .req_err_a       (req_err_a),
      .req_err_b       (req_err_b),
      .req_err_c       (req_err_c),
      .req_err_d       (req_err_d),
      .req_word_a      (req_word_a),
      .req_word_b      (req_word_b),
      .req_word_c      (req_word_c),
      .req_word_d      (req_word_d),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .push            (push),
      .push_entry      (push_entry)
   );

   rgd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   rgd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_value  (rsp_event_value),
      .rsp_char_address (rsp_char_address),
      .rsp_text_ab      (rsp_text_ab),
      .rsp_char_count   (rsp_char_count),
      .rsp_char0        (rsp_char0),
      .rsp_char1        (rsp_char1),
      .rsp_char2        (rsp_char2),
      .rsp_char3        (rsp_char3),
      .rsp_last         (rsp_last)
   );

   // Events of one group leave in consecutive cycles.
   `RGD_ASSERT_NXT(a_group_contiguous, clock, reset, rsp_valid && !rsp_last, rsp_valid)
   // A waiting group in the queue is always followed by a valid event word at the output.
   `RGD_ASSERT_NXT(a_queue_drains, clock, reset, q_status.not_empty, ##1 rsp_valid)
   // A programme-service event carries exactly one character.
   `RGD_ASSERT_IMP(a_ps_single_char, clock, reset,
      rsp_valid && (rsp_event_kind == EV_PS), rsp_char_count == 3'd1)

endmodule

/* test/tb_rds_group_dispatcher.sv */
// Self-checking testbench for the RDS group dispatcher: directed and random groups checked against predicted events.
`timescale 1ns / 1ps

module tb_rds_group_dispatcher;
   import rgd_pkg::*;

   localparam logic [4:0] GtypeClockTime = 5'd8;
   localparam int unsigned SettleCycles = 16;
   localparam int unsigned CycleLimit = 300000;
   localparam int unsigned PhaseGroups = 32;

   typedef struct {
      logic        valid;
      logic [1:0]  err_a;
      logic [1:0]  err_b;
      logic [1:0]  err_c;
      logic [1:0]  err_d;
      logic [15:0] word_a;
      logic [15:0] word_b;
      logic [15:0] word_c;
      logic [15:0] word_d;
   } rds_group_type;

   typedef struct {
      rgd_kind_type kind;
      logic [15:0]  value;
      logic [3:0]   addr;
      logic         ab;
      logic [2:0]   count;
      logic [7:0]   c0;
      logic [7:0]   c1;
      logic [7:0]   c2;
      logic [7:0]   c3;
      logic         last;
   } rds_event_type;

   class GroupEventLedger;
      logic [1:0]    b_limit;
      logic [1:0]    other_limit;
      rds_event_type pending_events[$];
      int unsigned   faults;

      function new();
         b_limit = BlockBMaxReset;
         other_limit = OtherMaxReset;
         faults = 0;
      endfunction

      function void set_limit(logic index, logic [1:0] value);
         if (index == CSR_BLOCK_B_MAX) begin
            b_limit = value;
         end else begin
            other_limit = value;
         end
      endfunction

      function int unsigned pending();
         return pending_events.size();
      endfunction

      function void add(rgd_kind_type kind, logic [15:0] value, logic [3:0] addr, logic ab,
                        logic [2:0] count, logic [7:0] c0, logic [7:0] c1,
                        logic [7:0] c2, logic [7:0] c3);
         rds_event_type ev;
         ev.kind = kind;
         ev.value = value;
         ev.addr = addr;
         ev.ab = ab;
         ev.count = count;
         ev.c0 = c0;
         ev.c1 = c1;
         ev.c2 = c2;
         ev.c3 = c3;
         ev.last = 1'b0;
         pending_events.push_back(ev);
      endfunction

      function void note_group(rds_group_type g);
         logic [4:0]    gtype;
         logic          a_ok;
         logic          c_ok;
         logic          d_ok;
         logic [3:0]    ps_addr;
         rds_event_type tail;
         if (!g.valid || g.err_b > b_limit) return;
         gtype = g.word_b[15:11];
         a_ok = g.err_a <= other_limit;
         c_ok = g.err_c <= other_limit;
         d_ok = g.err_d <= other_limit;
         ps_addr = {1'b0, g.word_b[1:0], 1'b0};
         if (a_ok) add(EV_PI, g.word_a, 0, 0, 0, 0, 0, 0, 0);
         if (gtype[0] && c_ok) add(EV_PI, g.word_c, 0, 0, 0, 0, 0, 0, 0);
         add(EV_PTY, {11'd0, g.word_b[9:5]}, 0, 0, 0, 0, 0, 0, 0);
         add(EV_TP, {15'd0, g.word_b[10]}, 0, 0, 0, 0, 0, 0, 0);
         if (gtype == GTYPE_0A || gtype == GTYPE_0B) begin
            if (gtype == GTYPE_0A && c_ok) add(EV_AF, g.word_c, 0, 0, 0, 0, 0, 0, 0);
            add(EV_TA, {15'd0, g.word_b[4]}, 0, 0, 0, 0, 0, 0, 0);
            if (d_ok) begin
               add(EV_PS, 0, ps_addr, 0, 3'd1, g.word_d[15:8], 0, 0, 0);
               add(EV_PS, 0, ps_addr | 4'd1, 0, 3'd1, g.word_d[7:0], 0, 0, 0);
            end
         end else if (gtype == GTYPE_2A) begin
            if (c_ok && d_ok) begin
               add(EV_RT, 0, g.word_b[3:0], g.word_b[4], 3'd4, g.word_c[15:8], g.word_c[7:0],
                   g.word_d[15:8], g.word_d[7:0]);
            end
         end else if (gtype == GTYPE_2B) begin
            if (d_ok) begin
               add(EV_RT, 0, g.word_b[3:0], g.word_b[4], 3'd2, g.word_d[15:8], g.word_d[7:0],
                   0, 0);
            end
         end
         tail = pending_events.pop_back();
         tail.last = 1'b1;
         pending_events.push_back(tail);
      endfunction

      function void flag(string what, logic [15:0] want, logic [15:0] got);
         if (want !== got) begin
            faults++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         end
      endfunction

      function void check_event(rds_event_type got);
         rds_event_type want;
         if (pending_events.size() == 0) begin
            faults++;
            $display("%0t: event word with none expected, expected nothing, actual kind %0d",
                     $time, got.kind);
            return;
         end
         want = pending_events.pop_front();
         flag("event_kind", want.kind, got.kind);
         flag("event_value", want.value, got.value);
         flag("char_address", want.addr, got.addr);
         flag("text_ab", want.ab, got.ab);
         flag("char_count", want.count, got.count);
         flag("char0", want.c0, got.c0);
         flag("char1", want.c1, got.c1);
         flag("char2", want.c2, got.c2);
         flag("char3", want.c3, got.c3);
         flag("last", want.last, got.last);
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_group_valid = 1'b0;
   logic [1:0]  req_err_a = 2'd0;
   logic [1:0]  req_err_b = 2'd0;
   logic [1:0]  req_err_c = 2'd0;
   logic [1:0]  req_err_d = 2'd0;
   logic [15:0] req_word_a = 16'd0;
   logic [15:0] req_word_b = 16'd0;
   logic [15:0] req_word_c = 16'd0;
   logic [15:0] req_word_d = 16'd0;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_BLOCK_B_MAX;
   logic [1:0]  csr_wdata = 2'd0;
   logic        rsp_valid;
   logic [2:0]  rsp_event_kind;
   logic [15:0] rsp_event_value;
   logic [3:0]  rsp_char_address;
   logic        rsp_text_ab;
   logic [2:0]  rsp_char_count;
   logic [7:0]  rsp_char0;
   logic [7:0]  rsp_char1;
   logic [7:0]  rsp_char2;
   logic [7:0]  rsp_char3;
   logic        rsp_last;

   GroupEventLedger ledger;
   int unsigned burst_left = 0;

   rds_group_dispatcher dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_group_valid(req_group_valid),
      .req_err_a(req_err_a),
      .req_err_b(req_err_b),
      .req_err_c(req_err_c),
      .req_err_d(req_err_d),
      .req_word_a(req_word_a),
      .req_word_b(req_word_b),
      .req_word_c(req_word_c),
      .req_word_d(req_word_d),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_event_kind(rsp_event_kind),
      .rsp_event_value(rsp_event_value),
      .rsp_char_address(rsp_char_address),
      .rsp_text_ab(rsp_text_ab),
      .rsp_char_count(rsp_char_count),
      .rsp_char0(rsp_char0),
      .rsp_char1(rsp_char1),
      .rsp_char2(rsp_char2),
      .rsp_char3(rsp_char3),
      .rsp_last(rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin : watch_events
      rds_event_type got;
      if (!reset && rsp_valid) begin
         got.kind = rgd_kind_type'(rsp_event_kind);
         got.value = rsp_event_value;
         got.addr = rsp_char_address;
         got.ab = rsp_text_ab;
         got.count = rsp_char_count;
         got.c0 = rsp_char0;
         got.c1 = rsp_char1;
         got.c2 = rsp_char2;
         got.c3 = rsp_char3;
         got.last = rsp_last;
         ledger.check_event(got);
      end
   end

   function automatic rds_group_type make_group(logic valid, logic [1:0] ea, logic [1:0] eb,
                                                logic [1:0] ec, logic [1:0] ed,
                                                logic [15:0] wa, logic [15:0] wb,
                                                logic [15:0] wc, logic [15:0] wd);
      rds_group_type g;
      g.valid = valid;
      g.err_a = ea;
      g.err_b = eb;
      g.err_c = ec;
      g.err_d = ed;
      g.word_a = wa;
      g.word_b = wb;
      g.word_c = wc;
      g.word_d = wd;
      return g;
   endfunction

   function automatic logic [1:0] random_err();
      return ($urandom_range(0, 1) == 0) ? 2'd0 : 2'($urandom_range(0, 3));
   endfunction

   function automatic rds_group_type random_group();
      rds_group_type g;
      logic [4:0]    gtype;
      int unsigned   pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: gtype = GTYPE_0A;
         2, 3: gtype = GTYPE_0B;
         4, 5: gtype = GTYPE_2A;
         6, 7: gtype = GTYPE_2B;
         8: gtype = GtypeClockTime;
         default: gtype = 5'($urandom_range(0, 31));
      endcase
      g = make_group($urandom_range(0, 99) < 92, random_err(), random_err(), random_err(),
                     random_err(), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
      g.word_b[15:11] = gtype;
      return g;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic drive_group(input rds_group_type g);
      req_group_valid <= g.valid;
      req_err_a <= g.err_a;
      req_err_b <= g.err_b;
      req_err_c <= g.err_c;
      req_err_d <= g.err_d;
      req_word_a <= g.word_a;
      req_word_b <= g.word_b;
      req_word_c <= g.word_c;
      req_word_d <= g.word_d;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      ledger.note_group(g);
   endtask

   task automatic hold_off(input int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [1:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      ledger.set_limit(index, value);
      @(posedge clock);
   endtask

   task automatic run_directed();
      rds_group_type list[$];
      list.push_back(make_group(0, 0, 0, 0, 0, 16'h1234, {GTYPE_0A, 11'h7FF}, 16'h5678,
                                16'h9ABC));
      list.push_back(make_group(1, 0, 2, 0, 0, 16'h1234, {GTYPE_0A, 11'h7FF}, 16'h5678,
                                16'h9ABC));
      list.push_back(make_group(1, 0, 1, 0, 0, 16'hFFFF, {GTYPE_0A, 11'h7FF}, 16'hFFFF,
                                16'hFFFF));
      list.push_back(make_group(1, 0, 0, 0, 0, 16'h0000, {GTYPE_0A, 11'h000}, 16'h0000,
                                16'h0000));
      list.push_back(make_group(1, 3, 0, 3, 0, 16'hA5A5, {GTYPE_0A, 11'h2AA}, 16'h5A5A,
                                16'h4142));
      list.push_back(make_group(1, 2, 0, 2, 3, 16'h5A5A, {GTYPE_0A, 11'h555}, 16'hA5A5,
                                16'h4344));
      list.push_back(make_group(1, 0, 0, 0, 0, 16'hC001, {GTYPE_0B, 11'h413}, 16'hC002,
                                16'h4546));
      list.push_back(make_group(1, 0, 0, 3, 2, 16'hC003, {GTYPE_0B, 11'h3E1}, 16'hC004,
                                16'h4748));
      list.push_back(make_group(1, 0, 1, 0, 0, 16'h2001, {GTYPE_2A, 11'h7FF}, 16'hFFFF,
                                16'hFFFF));
      list.push_back(make_group(1, 0, 0, 0, 0, 16'h2002, {GTYPE_2A, 11'h000}, 16'h0000,
                                16'h0000));
      list.push_back(make_group(1, 0, 0, 3, 0, 16'h2003, {GTYPE_2A, 11'h01A}, 16'h4849,
                                16'h4A4B));
      list.push_back(make_group(1, 0, 0, 0, 3, 16'h2004, {GTYPE_2A, 11'h005}, 16'h4C4D,
                                16'h4E4F));
      list.push_back(make_group(1, 0, 0, 0, 0, 16'h2005, {GTYPE_2B, 11'h01F}, 16'h5051,
                                16'h5253));
      list.push_back(make_group(1, 0, 0, 3, 0, 16'h2006, {GTYPE_2B, 11'h7E0}, 16'h5455,
                                16'hFFFF));
      list.push_back(make_group(1, 3, 0, 0, 3, 16'h2007, {GTYPE_2B, 11'h00C}, 16'h5657,
                                16'h5859));
      list.push_back(make_group(1, 0, 0, 0, 0, 16'h4001, {GtypeClockTime, 11'h7FF},
                                16'h1111, 16'h2222));
      list.push_back(make_group(1, 0, 0, 0, 0, 16'h4002, {5'd31, 11'h400}, 16'h3333,
                                16'h4444));
      list.push_back(make_group(1, 0, 0, 3, 0, 16'h4003, {5'd3, 11'h020}, 16'h5555,
                                16'h6666));
      list.push_back(make_group(1, 3, 3, 3, 3, 16'h4004, {GTYPE_0A, 11'h123}, 16'h7777,
                                16'h8888));
      list.push_back(make_group(1, 3, 1, 3, 3, 16'h4005, {GTYPE_0B, 11'h321}, 16'h9999,
                                16'hAAAA));
      foreach (list[i]) begin
         drive_group(list[i]);
         hold_off((i % 4 == 3) ? $urandom_range(1, 5) : 0);
      end
   endtask

   task automatic run_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         drive_group(random_group());
         if (burst_left == 0 && $urandom_range(0, 19) == 0) burst_left = $urandom_range(6, 14);
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            hold_off(pick_gap());
         end
      end
   endtask

   initial begin
      logic [1:0] b_set[6];
      logic [1:0] other_set[6];
      b_set = '{2'd0, 2'd3, 2'd0, 2'd3, 2'd2, 2'd1};
      other_set = '{2'd0, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2};
      ledger = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      drain();
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_BLOCK_B_MAX, b_set[p]);
         write_reg(CSR_OTHER_MAX, other_set[p]);
         run_random(PhaseGroups);
         drain();
      end
      if (ledger.faults == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
